>>> hdl/hgps_pkg.sv
`timescale 1ns / 1ps

package hgps_pkg;

	// sizing
	localparam int QUEUE_DEPTH = 2;
	localparam int SCORE_W     = 26;
	localparam int NUM_CAND    = 13;
	localparam int CAND_ID_W   = 4;

	// snap kinds
	localparam logic [1:0] KIND_CENTRE = 2'd0;
	localparam logic [1:0] KIND_VERTEX = 2'd1;
	localparam logic [1:0] KIND_EDGE   = 2'd2;

	// register indexes
	localparam logic [1:0] REG_ORIGIN_X  = 2'd0;
	localparam logic [1:0] REG_ORIGIN_Y  = 2'd1;
	localparam logic [1:0] REG_INV_DIV_X = 2'd2;
	localparam logic [1:0] REG_INV_DIV_Y = 2'd3;

	localparam logic [31:0] ORIGIN_RST  = 32'd0;
	localparam logic [31:0] INV_DIV_RST = 32'd16777216;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} point_t;

	typedef struct packed {
		logic [1:0]         snap_kind;
		logic signed [19:0] index_x;
		logic signed [19:0] index_y;
	} result_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic [31:0]        inv_div_x;
		logic [31:0]        inv_div_y;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic signed [36:0] sx;
		logic signed [37:0] sy;
		logic signed [19:0] dx0;
		logic signed [19:0] dy0;
	} snap_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// candidate order: centre, then vertex i, edge i for i = 0..5
	function automatic logic signed [3:0] cand_dx(input logic [CAND_ID_W-1:0] id);
		logic signed [3:0] r;
		case (id)
			4'd1:    r = 4'sd4;
			4'd2:    r = 4'sd3;
			4'd3:    r = 4'sd2;
			4'd4:    r = 4'sd0;
			4'd5:    r = -4'sd2;
			4'd6:    r = -4'sd3;
			4'd7:    r = -4'sd4;
			4'd8:    r = -4'sd3;
			4'd9:    r = -4'sd2;
			4'd10:   r = 4'sd0;
			4'd11:   r = 4'sd2;
			4'd12:   r = 4'sd3;
			default: r = 4'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [3:0] cand_dy(input logic [CAND_ID_W-1:0] id);
		logic signed [3:0] r;
		case (id)
			4'd1:    r = 4'sd0;
			4'd2:    r = 4'sd3;
			4'd3:    r = 4'sd6;
			4'd4:    r = 4'sd6;
			4'd5:    r = 4'sd6;
			4'd6:    r = 4'sd3;
			4'd7:    r = 4'sd0;
			4'd8:    r = -4'sd3;
			4'd9:    r = -4'sd6;
			4'd10:   r = -4'sd6;
			4'd11:   r = -4'sd6;
			4'd12:   r = -4'sd3;
			default: r = 4'sd0;
		endcase
		return r;
	endfunction

	// squared length of the offset
	function automatic logic [5:0] cand_norm(input logic [CAND_ID_W-1:0] id);
		logic [5:0] r;
		case (id)
			4'd1, 4'd7:                  r = 6'd16;
			4'd2, 4'd6, 4'd8, 4'd12:     r = 6'd18;
			4'd3, 4'd5, 4'd9, 4'd11:     r = 6'd40;
			4'd4, 4'd10:                 r = 6'd36;
			default:                     r = 6'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] cand_kind(input logic [CAND_ID_W-1:0] id);
		logic [1:0] r;
		if (id == 4'd0) begin
			r = KIND_CENTRE;
		end else if (id[0]) begin
			r = KIND_VERTEX;
		end else begin
			r = KIND_EDGE;
		end
		return r;
	endfunction

endpackage

>>> hdl/hgps_front.sv
`timescale 1ns / 1ps

module hgps_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  hgps_pkg::point_t      point,
	input  hgps_pkg::cfg_t        cfg,
	input  logic                  q_full,
	output logic                  busy,
	output logic                  push,
	output hgps_pkg::snap_job_t   job
);

	localparam logic signed [50:0] COL_BIAS  = 51'sd150733;
	localparam logic signed [51:0] ROW_HALF  = 52'sd65536;
	localparam logic signed [19:0] UX_SHIFT  = 20'sd125611;
	localparam logic signed [17:0] FRAC_HALF = 18'sd65536;
	localparam logic [34:0]        RECIP3    = 35'h555555556;

	logic adv, accept;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [32:0] lx_d, dy_d;
	logic signed [32:0] lx_s1;
	logic signed [33:0] ly_s1;
	logic signed [49:0] px_hi_s2, px_lo_s2;
	logic signed [50:0] py_hi_s2, py_lo_s2;
	logic signed [49:0] cx_s3;
	logic signed [50:0] cy_s3;
	logic signed [50:0] v_d;
	logic signed [51:0] cyr_d;
	logic [34:0]        u_s4;
	logic [15:0]        vlo_s4, vlo_s5, vlo_s6;
	logic [2:0]         t3_s4, t3_s5, t3_s6;
	logic [33:0]        row_e_s4, row_e_s5, row_e_s6;
	logic [33:0]        row_o_s4, row_o_s5, row_o_s6;
	logic [16:0]        cyl_s4, cyl_s5, cyl_s6;
	logic [33:0]        p11_s5;
	logic [34:0]        p10_s5, p01_s5;
	logic [35:0]        p00_s5;
	logic [35:0]        mid_d;
	logic [69:0]        prod_d;
	logic [33:0]        q_s6;

	logic signed [33:0] bucket;
	logic signed [36:0] be;
	logic [2:0]         tm6;
	logic               odd;
	logic signed [37:0] re, twelve;
	logic signed [17:0] g;
	logic signed [19:0] ge;

	assign adv    = !(v_s6 && q_full);
	assign busy   = !adv;
	assign accept = start && adv;
	assign push   = v_s6 && !q_full;

	assign lx_d  = $signed({point.point_x[31], point.point_x}) -
		$signed({cfg.origin_x[31], cfg.origin_x});
	assign dy_d  = $signed({point.point_y[31], point.point_y}) -
		$signed({cfg.origin_y[31], cfg.origin_y});
	assign v_d   = $signed({cx_s3[49], cx_s3}) + COL_BIAS;
	assign cyr_d = $signed({cy_s3[50], cy_s3}) + ROW_HALF;
	assign mid_d = {1'b0, p10_s5} + {1'b0, p01_s5};
	assign prod_d = {p11_s5, 36'd0} + {16'd0, mid_d, 18'd0} + {34'd0, p00_s5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// grid-local point, y doubled
			lx_s1 <= lx_d;
			ly_s1 <= {dy_d, 1'b0};
			// reciprocal scale in two 16-bit halves
			px_hi_s2 <= lx_s1 * $signed({1'b0, cfg.inv_div_x[31:16]});
			px_lo_s2 <= lx_s1 * $signed({1'b0, cfg.inv_div_x[15:0]});
			py_hi_s2 <= ly_s1 * $signed({1'b0, cfg.inv_div_y[31:16]});
			py_lo_s2 <= ly_s1 * $signed({1'b0, cfg.inv_div_y[15:0]});
			cx_s3 <= px_hi_s2 + (px_lo_s2 >>> 16);
			cy_s3 <= py_hi_s2 + (py_lo_s2 >>> 16);
			// floor(t/2) offset by 3 * 2^33 so the divide by 3 is unsigned
			u_s4     <= {1'b1, ~v_d[50], v_d[49:17]};
			vlo_s4   <= v_d[15:0];
			t3_s4    <= v_d[18:16];
			row_e_s4 <= cyr_d[50:17];
			row_o_s4 <= cy_s3[50:17];
			cyl_s4   <= cy_s3[16:0];
			// divide by 3 through the reciprocal, partial products
			p11_s5   <= u_s4[34:18] * RECIP3[34:18];
			p10_s5   <= u_s4[34:18] * RECIP3[17:0];
			p01_s5   <= u_s4[17:0] * RECIP3[34:18];
			p00_s5   <= u_s4[17:0] * RECIP3[17:0];
			vlo_s5   <= vlo_s4;
			t3_s5    <= t3_s4;
			row_e_s5 <= row_e_s4;
			row_o_s5 <= row_o_s4;
			cyl_s5   <= cyl_s4;
			q_s6     <= prod_d[69:36];
			vlo_s6   <= vlo_s5;
			t3_s6    <= t3_s5;
			row_e_s6 <= row_e_s5;
			row_o_s6 <= row_o_s5;
			cyl_s6   <= cyl_s5;
		end
	end

	// classify: column bucket, row snap, offsets from the centre
	always_comb begin
		bucket = {~q_s6[33], q_s6[32:0]};
		be     = 37'(bucket);
		job.sx = (be <<< 2) + (be <<< 1);
		tm6    = t3_s6 - job.sx[2:0];
		job.dx0 = $signed({1'b0, tm6, vlo_s6}) - UX_SHIFT;
		odd    = q_s6[0];
		re     = odd ? 38'($signed(row_o_s6)) : 38'($signed(row_e_s6));
		twelve = (re <<< 3) + (re <<< 2);
		job.sy = odd ? (twelve + 38'sd6) : twelve;
		g      = odd ? ($signed({1'b0, cyl_s6}) - FRAC_HALF) : 18'($signed(cyl_s6));
		ge     = 20'(g);
		job.dy0 = (ge <<< 2) + (ge <<< 1);
	end

endmodule

>>> hdl/hgps_queue.sv
`timescale 1ns / 1ps

module hgps_queue #(
	parameter int DEPTH = hgps_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  hgps_pkg::snap_job_t   push_data,
	input  logic                  pop,
	output hgps_pkg::snap_job_t   pop_data,
	output hgps_pkg::q_status_t   status
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	hgps_pkg::snap_job_t mem [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic do_push, do_pop;

	assign status.full  = (cnt_q == CW'(DEPTH));
	assign status.empty = (cnt_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_data     = mem[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/hgps_back.sv
`timescale 1ns / 1ps

module hgps_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  job_valid,
	input  hgps_pkg::snap_job_t   job,
	output logic                  done,
	output hgps_pkg::result_t     result
);

	localparam int SW = hgps_pkg::SCORE_W;
	localparam int IW = hgps_pkg::CAND_ID_W;
	localparam int NC = hgps_pkg::NUM_CAND;

	typedef struct packed {
		logic signed [SW-1:0] score;
		logic [IW-1:0]        id;
	} cand_t;

	function automatic cand_t pick(input cand_t a, input cand_t b);
		return (b.score < a.score) ? b : a;
	endfunction

	function automatic logic signed [19:0] sat_idx(input logic signed [38:0] v);
		logic signed [19:0] r;
		if (v > 39'sd524287) begin
			r = 20'sd524287;
		end else if (v < -39'sd524288) begin
			r = -20'sd524288;
		end else begin
			r = v[19:0];
		end
		return r;
	endfunction

	cand_t score_d [NC];
	cand_t score_s1 [NC];
	cand_t l1 [7];
	cand_t l2_s2 [4];
	cand_t l3 [2];
	cand_t win;
	logic v_s1, v_s2, v_s3;
	logic signed [36:0] sx_s1, sx_s2, sx_s3;
	logic signed [37:0] sy_s1, sy_s2, sy_s3;
	logic [IW-1:0] id_s3;
	logic signed [38:0] ix, iy;

	// score_i = norm_i * 2^15 - (d . offset_i), same order as squared distance
	always_comb begin
		for (int c = 0; c < NC; c++) begin
			score_d[c].id = IW'(c);
			score_d[c].score = $signed(SW'(hgps_pkg::cand_norm(IW'(c))) << 15) -
				(SW'(job.dx0) * SW'(hgps_pkg::cand_dx(IW'(c))) +
				 SW'(job.dy0) * SW'(hgps_pkg::cand_dy(IW'(c))));
		end
	end

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			l1[k] = pick(score_s1[2*k], score_s1[2*k+1]);
		end
		l1[6] = score_s1[12];
		l3[0] = pick(l2_s2[0], l2_s2[1]);
		l3[1] = pick(l2_s2[2], l2_s2[3]);
		win   = pick(l3[0], l3[1]);
	end

	assign ix = $signed(39'(sx_s3)) + 39'(hgps_pkg::cand_dx(id_s3));
	assign iy = $signed(39'(sy_s3)) + 39'(hgps_pkg::cand_dy(id_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= job_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			done <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		score_s1 <= score_d;
		sx_s1 <= job.sx;
		sy_s1 <= job.sy;
		l2_s2[0] <= pick(l1[0], l1[1]);
		l2_s2[1] <= pick(l1[2], l1[3]);
		l2_s2[2] <= pick(l1[4], l1[5]);
		l2_s2[3] <= l1[6];
		sx_s2 <= sx_s1;
		sy_s2 <= sy_s1;
		id_s3 <= win.id;
		sx_s3 <= sx_s2;
		sy_s3 <= sy_s2;
		result.snap_kind <= hgps_pkg::cand_kind(id_s3);
		result.index_x   <= sat_idx(ix);
		result.index_y   <= sat_idx(iy);
	end

endmodule

>>> hdl/hex_grid_point_snap.sv
`timescale 1ns / 1ps
// an accepted request passes front, queue and back, then shows on result with done high
// throughput: one request per cycle, sustained; busy rises only if the front/back queue fills
// the receiver cannot stall, so the back end drains the queue every cycle
// reset: arst_n clears pipeline valids and queue pointers, registers return to origin 0 and
//   reciprocal 1.0; there is no clearing pass, the block accepts right after reset

module hex_grid_point_snap #(
	parameter int QUEUE_DEPTH = hgps_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	// request side
	input  logic                start,
	output logic                busy,
	input  hgps_pkg::point_t    point,
	// result side
	output logic                done,
	output hgps_pkg::result_t   result,
	// configuration write port
	input  logic                cfg_we,
	input  logic [1:0]          cfg_idx,
	input  logic [31:0]         cfg_data
);

	// configuration registers; the user must write them only while the block is idle (not enforced here)
	hgps_pkg::cfg_t cfg_q;

	// front to queue
	logic                 push;
	hgps_pkg::snap_job_t  push_job;

	// queue to back
	hgps_pkg::snap_job_t  pop_job;
	hgps_pkg::q_status_t  q_stat;
	logic                 pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x  <= hgps_pkg::ORIGIN_RST;
			cfg_q.origin_y  <= hgps_pkg::ORIGIN_RST;
			cfg_q.inv_div_x <= hgps_pkg::INV_DIV_RST;
			cfg_q.inv_div_y <= hgps_pkg::INV_DIV_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				hgps_pkg::REG_ORIGIN_X:  cfg_q.origin_x  <= cfg_data;
				hgps_pkg::REG_ORIGIN_Y:  cfg_q.origin_y  <= cfg_data;
				hgps_pkg::REG_INV_DIV_X: cfg_q.inv_div_x <= cfg_data;
				hgps_pkg::REG_INV_DIV_Y: cfg_q.inv_div_y <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: origin subtract, reciprocal scale (split into 16-bit halves),
	// column bucket by divide-by-6 through a reciprocal multiply, row snap,
	// and the reference point relative to the candidate centre
	hgps_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.point  (point),
		.cfg    (cfg_q),
		.q_full (q_stat.full),
		.busy   (busy),
		.push   (push),
		.job    (push_job)
	);

	// short queue between the two halves; the front holds when it is full
	hgps_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.pop       (pop),
		.pop_data  (pop_job),
		.status    (q_stat)
	);

	// back never stalls: take the head whenever one is there
	assign pop = !q_stat.empty;

	// back: 13 candidate scores, a two-stage tournament where the earlier
	// candidate wins ties, then index add and saturation
	hgps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop),
		.job       (pop_job),
		.done      (done),
		.result    (result)
	);

endmodule
